// File: design/ubh_pkg.sv
package ubh_pkg;

   localparam int DEF_MAX_BINS    = 64;
   localparam int DEF_COUNT_WIDTH = 32;

   // widest bin address over the full MAX_BINS range (up to 4096 bins)
   localparam int BIN_ADDR_W  = 12;
   localparam int QUEUE_DEPTH = 2;

   localparam int CMD_W      = 2;
   localparam int SAMPLE_W   = 32;
   localparam int RIDX_W     = 6;
   localparam int REPORT_W   = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int BIN_CNT_W  = 7;
   localparam int USED_W     = 13;

   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_LEFT_EDGE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INVERSE_WIDTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BIN_COUNT     = 2'd2;

   localparam logic signed [SAMPLE_W-1:0] RST_LEFT_EDGE     = -32'sd196608;
   localparam logic [SAMPLE_W-1:0]        RST_INVERSE_WIDTH = 32'd218453;
   localparam logic [BIN_CNT_W-1:0]       RST_BIN_COUNT     = 7'd20;

   // work classes handed from the front to the back
   typedef enum logic [2:0] {
      OP_ADD_IN,    // sample lands in a bin
      OP_ADD_OUT,   // sample counts as out of range
      OP_READ,      // read an existing bin
      OP_READ_OUT,  // read past the bin store, reports zero
      OP_CLEAR,     // zero all counters
      OP_NOP        // unused command
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [BIN_ADDR_W-1:0]   addr;
      logic [RIDX_W-1:0]       bidx;
   } entry_type;

endpackage

// File: design/uniform_bin_histogram.sv
// Equal-width bin histogram engine.
// req_ channel: one transaction per command. tuser carries the command (add sample,
//   read bin, clear all counters); tdata carries the Q16.16 sample and the bin to read.
// rsp_ channel: exactly one transaction per request, in request order, with the
//   in-range flag, bin index, read count and the current out-of-range total.
// csr_ channel: writes the left edge of bin 0 (0), inverse_width (1) and
//   bin_count (2); always ready. The user must write it only while the block holds no
//   work; the block itself does not enforce this.
// Add computes floor((sample - left edge) * inverse_width) exactly through one
//   32x32 multiplier; counters saturate at their maximum.
// The back end takes one add or read at a time: it reads the bin memory as it takes
//   the entry and updates it on execution. A clear command holds it for a clearing pass.
// Reset: a clearing pass writes zero to all MAX_BINS bins, one per cycle; req_tready
//   stays low until that pass ends. Configuration returns to its reset values.
// Stalls: the result sits in an output register; the front pipe and a two-entry
//   queue keep taking requests until they fill, then req_tready drops.
module uniform_bin_histogram
   import ubh_pkg::*;
#(
   parameter int MAX_BINS    = DEF_MAX_BINS,
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [39:0]           req_tdata,   // sample[31:0], read_index[37:32], zero pad
   input  logic [CMD_W-1:0]      req_tuser,   // command[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [71:0]           rsp_tdata,   // in_range[0], bin_index[6:1],
                                              // bin_value[38:7], outside_total[70:39], pad
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]           csr_data
);

   // configuration registers
   logic signed [SAMPLE_W-1:0]  left_edge_ff;
   logic [SAMPLE_W-1:0]         inverse_width_ff;
   logic [BIN_CNT_W-1:0]        bin_count_ff;

   logic        init_done;
   logic        push_valid;
   logic        push_ready;
   entry_type   push_data;
   logic        pop_valid;
   logic        pop_ready;
   entry_type   pop_data;

   logic                 rsp_in_range;
   logic [RIDX_W-1:0]    rsp_bin_index;
   logic [REPORT_W-1:0]  rsp_bin_value;
   logic [REPORT_W-1:0]  rsp_outside_total;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_edge_ff     <= RST_LEFT_EDGE;
         inverse_width_ff <= RST_INVERSE_WIDTH;
         bin_count_ff     <= RST_BIN_COUNT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_LEFT_EDGE:     left_edge_ff     <= csr_data;
            REG_INVERSE_WIDTH: inverse_width_ff <= csr_data;
            REG_BIN_COUNT:     bin_count_ff     <= csr_data[BIN_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // front: offset, scale, classify
   ubh_front #(
      .MAX_BINS (MAX_BINS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .init_done     (init_done),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_command    (req_tuser),
      .in_sample     (req_tdata[31:0]),
      .in_read_index (req_tdata[37:32]),
      .left_edge     (left_edge_ff),
      .inverse_width (inverse_width_ff),
      .bin_count     (bin_count_ff),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_data     (push_data)
   );

   ubh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // back: bin memory, counters, result register
   ubh_back #(
      .MAX_BINS    (MAX_BINS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .init_done         (init_done),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_data          (pop_data),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .rsp_in_range      (rsp_in_range),
      .rsp_bin_index     (rsp_bin_index),
      .rsp_bin_value     (rsp_bin_value),
      .rsp_outside_total (rsp_outside_total)
   );

   assign rsp_tdata = {1'b0, rsp_outside_total, rsp_bin_value, rsp_bin_index, rsp_in_range};

   // no request taken while the reset clearing pass of the bin memory runs
   a_no_req_during_init: assert property (@(posedge clock) disable iff (reset)
      !init_done |-> !req_tready)
      else $error("request accepted during clearing pass");

   // an in-range add never reports a read count
   a_add_no_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_in_range) |-> (rsp_bin_value == '0))
      else $error("in-range add carries a bin value");

   // an in-range bin lies below the configured bin count
   a_bin_below_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_in_range) |-> (BIN_CNT_W'(rsp_bin_index) < bin_count_ff))
      else $error("in-range bin at or past bin_count");

endmodule

// File: design/ubh_front.sv
module ubh_front
   import ubh_pkg::*;
#(
   parameter int MAX_BINS = DEF_MAX_BINS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        init_done,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [CMD_W-1:0]            in_command,
   input  logic signed [SAMPLE_W-1:0]  in_sample,
   input  logic [RIDX_W-1:0]           in_read_index,
   input  logic signed [SAMPLE_W-1:0]  left_edge,
   input  logic [SAMPLE_W-1:0]         inverse_width,
   input  logic [BIN_CNT_W-1:0]        bin_count,
   output logic                        push_valid,
   input  logic                        push_ready,
   output entry_type                   push_data
);

   // stage 1: difference to the lower edge
   logic                        s1_valid_ff;
   logic [CMD_W-1:0]            s1_cmd_ff;
   logic signed [SAMPLE_W:0]    s1_diff_ff;
   logic [RIDX_W-1:0]           s1_ridx_ff;
   // stage 2: Q32.32 product, integer part kept
   logic                        s2_valid_ff;
   logic [CMD_W-1:0]            s2_cmd_ff;
   logic                        s2_neg_ff;
   logic [SAMPLE_W-1:0]         s2_bin_ff;
   logic [RIDX_W-1:0]           s2_ridx_ff;

   logic                        s2_take;
   logic                        s1_take;
   logic signed [SAMPLE_W:0]    diff_in;
   logic [2*SAMPLE_W-1:0]       prod_in;
   logic [USED_W-1:0]           used;
   logic                        add_ok;
   logic                        rd_ok;

   assign s2_take  = !s2_valid_ff || push_ready;
   assign s1_take  = !s1_valid_ff || s2_take;
   assign in_ready = s1_take && init_done;

   assign diff_in = {in_sample[SAMPLE_W-1], in_sample} -
                    {left_edge[SAMPLE_W-1], left_edge};
   assign prod_in = {{SAMPLE_W{1'b0}}, s1_diff_ff[SAMPLE_W-1:0]} *
                    {{SAMPLE_W{1'b0}}, inverse_width};

   assign used  = (USED_W'(bin_count) < USED_W'(MAX_BINS)) ? USED_W'(bin_count)
                                                            : USED_W'(MAX_BINS);
   // negative offset only lands in bin 0 when the scale is zero
   assign add_ok = s2_neg_ff ? ((inverse_width == '0) && (used != '0))
                             : (s2_bin_ff < SAMPLE_W'(used));
   assign rd_ok  = USED_W'(s2_ridx_ff) < USED_W'(MAX_BINS);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_take) begin
            s1_valid_ff <= in_valid && in_ready;
         end
         if (s2_take) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s1_cmd_ff  <= in_command;
         s1_diff_ff <= diff_in;
         s1_ridx_ff <= in_read_index;
      end
      if (s2_take && s1_valid_ff) begin
         s2_cmd_ff  <= s1_cmd_ff;
         s2_neg_ff  <= s1_diff_ff[SAMPLE_W];
         s2_bin_ff  <= prod_in[2*SAMPLE_W-1:SAMPLE_W];
         s2_ridx_ff <= s1_ridx_ff;
      end
   end

   always_comb begin
      push_valid     = s2_valid_ff;
      push_data.op   = OP_NOP;
      push_data.addr = '0;
      push_data.bidx = '0;
      unique case (s2_cmd_ff)
         CMD_ADD: begin
            if (add_ok) begin
               push_data.op = OP_ADD_IN;
               if (!s2_neg_ff) begin
                  push_data.addr = s2_bin_ff[BIN_ADDR_W-1:0];
                  push_data.bidx = s2_bin_ff[RIDX_W-1:0];
               end
            end else begin
               push_data.op = OP_ADD_OUT;
            end
         end
         CMD_READ: begin
            push_data.op   = rd_ok ? OP_READ : OP_READ_OUT;
            push_data.addr = BIN_ADDR_W'(s2_ridx_ff);
            push_data.bidx = s2_ridx_ff;
         end
         CMD_CLEAR: push_data.op = OP_CLEAR;
         default:   push_data.op = OP_NOP;
      endcase
   end

endmodule

// File: design/ubh_queue.sv
module ubh_queue
   import ubh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   output logic       push_ready,
   input  entry_type  push_data,
   output logic       pop_valid,
   input  logic       pop_ready,
   output entry_type  pop_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  level_ff;
   logic              do_push;
   logic              do_pop;

   assign push_ready = level_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = level_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            level_ff <= level_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            level_ff <= level_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: design/ubh_back.sv
module ubh_back
   import ubh_pkg::*;
#(
   parameter int MAX_BINS    = DEF_MAX_BINS,
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   output logic                  init_done,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  entry_type             pop_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_in_range,
   output logic [RIDX_W-1:0]     rsp_bin_index,
   output logic [REPORT_W-1:0]   rsp_bin_value,
   output logic [REPORT_W-1:0]   rsp_outside_total
);

   localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int CW    = COUNT_WIDTH;

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC} state_type;

   function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   // clamp a counter to the 32-bit report width
   function automatic logic [REPORT_W-1:0] rep32(input logic [CW-1:0] v);
      logic [CW+REPORT_W-1:0] wide;
      wide = {{REPORT_W{1'b0}}, v};
      return (wide[CW+REPORT_W-1:REPORT_W] != '0) ? '1 : wide[REPORT_W-1:0];
   endfunction

   logic [CW-1:0]      mem [MAX_BINS];
   logic [CW-1:0]      rd_data_ff;

   state_type          state_ff;
   logic [IDX_W-1:0]   clr_idx_ff;
   logic               init_done_ff;
   entry_type          cur_ff;
   logic [CW-1:0]      outside_ff;
   logic               rsp_valid_ff;
   logic               rsp_in_range_ff;
   logic [RIDX_W-1:0]  rsp_bin_index_ff;
   logic [REPORT_W-1:0] rsp_bin_value_ff;
   logic [REPORT_W-1:0] rsp_outside_total_ff;

   logic               pop;
   logic               exec_go;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [CW-1:0]      mem_wdata;
   logic [CW-1:0]      outside_inc;
   logic [CW-1:0]      outside_in;
   logic               rsp_in_range_in;
   logic [RIDX_W-1:0]  rsp_bin_index_in;
   logic [REPORT_W-1:0] rsp_bin_value_in;
   logic [REPORT_W-1:0] rsp_outside_total_in;

   assign pop       = (state_ff == ST_IDLE) && pop_valid;
   assign pop_ready = state_ff == ST_IDLE;
   assign exec_go   = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign outside_inc = sat_inc(outside_ff);

   assign mem_we    = (state_ff == ST_CLEAR) || (exec_go && (cur_ff.op == OP_ADD_IN));
   assign mem_waddr = (state_ff == ST_CLEAR) ? clr_idx_ff : cur_ff.addr[IDX_W-1:0];
   assign mem_wdata = (state_ff == ST_CLEAR) ? '0 : sat_inc(rd_data_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (pop) begin
         rd_data_ff <= mem[pop_data.addr[IDX_W-1:0]];
      end
   end

   // result fields and out-of-range counter for the transaction in execution
   always_comb begin
      outside_in           = outside_ff;
      rsp_in_range_in      = 1'b0;
      rsp_bin_index_in     = '0;
      rsp_bin_value_in     = '0;
      rsp_outside_total_in = rep32(outside_ff);
      case (cur_ff.op)
         OP_ADD_IN: begin
            rsp_in_range_in  = 1'b1;
            rsp_bin_index_in = cur_ff.bidx;
         end
         OP_ADD_OUT: begin
            outside_in           = outside_inc;
            rsp_outside_total_in = rep32(outside_inc);
         end
         OP_READ: begin
            rsp_bin_index_in = cur_ff.bidx;
            rsp_bin_value_in = rep32(rd_data_ff);
         end
         OP_READ_OUT: rsp_bin_index_in = cur_ff.bidx;
         OP_CLEAR: begin
            outside_in           = '0;
            rsp_outside_total_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         init_done_ff <= 1'b0;
         outside_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (exec_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_idx_ff <= clr_idx_ff + 1'b1;
               if (clr_idx_ff == IDX_W'(MAX_BINS - 1)) begin
                  state_ff     <= ST_IDLE;
                  init_done_ff <= 1'b1;
               end
            end
            ST_IDLE: begin
               if (pop) begin
                  cur_ff   <= pop_data;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (exec_go) begin
                  rsp_in_range_ff      <= rsp_in_range_in;
                  rsp_bin_index_ff     <= rsp_bin_index_in;
                  rsp_bin_value_ff     <= rsp_bin_value_in;
                  rsp_outside_total_ff <= rsp_outside_total_in;
                  outside_ff           <= outside_in;
                  if (cur_ff.op == OP_CLEAR) begin
                     clr_idx_ff <= '0;
                     state_ff   <= ST_CLEAR;
                  end else begin
                     state_ff   <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign init_done         = init_done_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_in_range      = rsp_in_range_ff;
   assign rsp_bin_index     = rsp_bin_index_ff;
   assign rsp_bin_value     = rsp_bin_value_ff;
   assign rsp_outside_total = rsp_outside_total_ff;

endmodule

// File: test/uniform_bin_histogram_test.sv
`timescale 1ns / 1ps

module uniform_bin_histogram_test;
   import ubh_pkg::*;

   // command code the block must ignore
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int BIN_SLOTS      = 64;
   localparam int WATCHDOG_LIMIT = 5000;
   // quiet time before a register write: a clear keeps the back end busy
   // with a clearing pass over all MAX_BINS bins after its response may already have left
   localparam int SETTLE_CYCLES  = 80;
   localparam int PHASE_ITEMS    = 92;
   localparam int PHASE_COUNT    = 6;
   localparam int PRINT_CAP      = 40;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [31:0]       sample;
      logic [RIDX_W-1:0] read_index;
   } hist_req_type;

   typedef struct packed {
      logic        in_range;
      logic [5:0]  bin_index;
      logic [31:0] bin_value;
      logic [31:0] outside_total;
   } hist_rsp_type;

   logic                 clock = 1'b1;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [39:0]          req_tdata = '0;
   logic [CMD_W-1:0]     req_tuser = CMD_ADD;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [71:0]          rsp_tdata;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = REG_LEFT_EDGE;
   logic [31:0]          csr_data = '0;

   uniform_bin_histogram dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // sample[31:0], read_index[37:32], zero pad
      .req_tuser  (req_tuser),   // command[1:0]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // in_range[0], bin_index[6:1], bin_value[38:7],
                                 // outside_total[70:39], pad
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // ---------------------------------------------------------------
   // Histogram shadow: configuration and counters as the block
   // should hold them after every accepted transaction.
   // ---------------------------------------------------------------
   logic [31:0] cfg_lower = RST_LEFT_EDGE;
   logic [31:0] cfg_invw  = RST_INVERSE_WIDTH;
   logic [6:0]  cfg_bins  = RST_BIN_COUNT;
   logic [31:0] bin_model [BIN_SLOTS];
   logic [31:0] outside_model = '0;

   hist_req_type pending_req[$];    // filled by the sequence, drained by the driver
   hist_rsp_type expected_rsp[$];   // predictions waiting for their response

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int error_count    = 0;
   int results_checked = 0;
   int adds_in = 0, adds_out = 0, reads_seen = 0, clears_seen = 0, nops_seen = 0;
   int csr_writes = 0;
   int stall_cycles = 0;

   initial begin
      for (int i = 0; i < BIN_SLOTS; i++) bin_model[i] = '0;
   end

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
   endfunction

   // Bin number is floor((sample - lower) * invw) with an exact 33-bit
   // difference; a negative difference only lands when invw is zero.
   task automatic histogram_predict(input hist_req_type r, output hist_rsp_type e);
      logic signed [32:0] diff;
      logic [63:0]        prod;
      logic [31:0]        bin;
      logic [31:0]        used_bins;
      logic               landed;
      e = '0;
      used_bins = (cfg_bins > 7'd64) ? 32'd64 : {25'd0, cfg_bins};
      case (r.command)
         CMD_ADD: begin
            diff = $signed({r.sample[31], r.sample}) - $signed({cfg_lower[31], cfg_lower});
            landed = 1'b0;
            bin = '0;
            if (!diff[32]) begin
               prod = {32'd0, diff[31:0]} * {32'd0, cfg_invw};
               bin = prod[63:32];
               landed = 1'b1;
            end else if (cfg_invw == '0) begin
               landed = 1'b1;
            end
            if (landed && bin < used_bins) begin
               bin_model[bin[5:0]] = sat_inc(bin_model[bin[5:0]]);
               e.in_range = 1'b1;
               e.bin_index = bin[5:0];
               adds_in++;
            end else begin
               outside_model = sat_inc(outside_model);
               adds_out++;
            end
         end
         CMD_READ: begin
            e.bin_index = r.read_index;
            e.bin_value = bin_model[r.read_index];
            reads_seen++;
         end
         CMD_CLEAR: begin
            for (int i = 0; i < BIN_SLOTS; i++) bin_model[i] = '0;
            outside_model = '0;
            clears_seen++;
         end
         default: nops_seen++;
      endcase
      e.outside_total = outside_model;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= PRINT_CAP)
         $display("[%0t] mismatch: %s got %0h expected %0h (response %0d)",
                  $time, what, got, want, results_checked);
   endtask

   // ---------------------------------------------------------------
   // Driver: one request transaction at a time from pending_req.
   // The request is predicted at the edge where it is accepted.
   // ---------------------------------------------------------------
   hist_req_type req_item = '0;
   hist_req_type next_req;
   hist_rsp_type req_prediction;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            histogram_predict(req_item, req_prediction);
            expected_rsp.push_back(req_prediction);
         end
         if (!req_tvalid || req_tready) begin
            if (pending_req.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               next_req = pending_req.pop_front();
               req_item   <= next_req;
               req_tdata  <= {2'b00, next_req.read_index, next_req.sample};
               req_tuser  <= next_req.command;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: random backpressure, field-by-field compare.
   // ---------------------------------------------------------------
   hist_rsp_type rsp_seen;
   hist_rsp_type rsp_want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen.in_range      = rsp_tdata[0];
            rsp_seen.bin_index     = rsp_tdata[6:1];
            rsp_seen.bin_value     = rsp_tdata[38:7];
            rsp_seen.outside_total = rsp_tdata[70:39];
            if (expected_rsp.size() == 0) begin
               report_mismatch("response with nothing pending, bin_index",
                               {26'd0, rsp_seen.bin_index}, '0);
            end else begin
               rsp_want = expected_rsp.pop_front();
               if (rsp_seen.in_range !== rsp_want.in_range)
                  report_mismatch("in_range", {31'd0, rsp_seen.in_range},
                                  {31'd0, rsp_want.in_range});
               if (rsp_seen.bin_index !== rsp_want.bin_index)
                  report_mismatch("bin_index", {26'd0, rsp_seen.bin_index},
                                  {26'd0, rsp_want.bin_index});
               if (rsp_seen.bin_value !== rsp_want.bin_value)
                  report_mismatch("bin_value", rsp_seen.bin_value, rsp_want.bin_value);
               if (rsp_seen.outside_total !== rsp_want.outside_total)
                  report_mismatch("outside_total", rsp_seen.outside_total,
                                  rsp_want.outside_total);
               results_checked++;
            end
         end
         rsp_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   // watchdog: any transaction on any channel restarts the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] watchdog: no transaction for %0d cycles, %0d responses pending",
                  $time, stall_cycles, expected_rsp.size());
         $display("status: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // Sequence helpers
   // ---------------------------------------------------------------
   task automatic queue_req(input logic [CMD_W-1:0] cmd, input logic [31:0] smp,
                            input logic [RIDX_W-1:0] ridx);
      hist_req_type r;
      r.command = cmd;
      r.sample = smp;
      r.read_index = ridx;
      pending_req.push_back(r);
   endtask

   // Caller sits on a rising edge; csr_valid is left high for back-to-back writes.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_LEFT_EDGE:     cfg_lower = data;
         REG_INVERSE_WIDTH: cfg_invw = data;
         REG_BIN_COUNT:     cfg_bins = data[6:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   // Sender holds off until the pipe is empty and every response is back.
   task automatic wait_drained();
      while (pending_req.size() != 0 || req_tvalid || expected_rsp.size() != 0)
         @(posedge clock);
   endtask

   // Sample near the populated bins: mostly spread across them (with a
   // margin either side), a quarter right on a bin boundary +/- 1 LSB.
   function automatic logic [31:0] pick_sample();
      logic [63:0]        used_bins;
      logic [63:0]        span;
      logic [63:0]        off;
      logic [63:0]        k;
      logic signed [63:0] val;
      used_bins = (cfg_bins > 7'd64) ? 64'd64 : {57'd0, cfg_bins};
      if (used_bins == 0) used_bins = 64'd8;
      if (cfg_invw == '0) span = 64'd1 << 20;
      else span = (used_bins << 32) / cfg_invw;
      if (span > (64'd1 << 34)) span = 64'd1 << 34;
      if ($urandom_range(3, 0) == 0) begin
         k = $urandom_range(used_bins[31:0], 0);
         off = (cfg_invw == '0) ? 64'd0 : ((k << 32) + cfg_invw - 1) / cfg_invw;
         off = off + $urandom_range(2, 0);
         off = off - 64'd1;
      end else begin
         off = {$urandom, $urandom} % (span + span / 4 + 1);
         off = off - span / 8;
      end
      val = $signed({{32{cfg_lower[31]}}, cfg_lower}) + $signed(off);
      if (val > 64'sh7FFF_FFFF) val = 64'sh7FFF_FFFF;
      else if (val < -64'sh8000_0000) val = -64'sh8000_0000;
      return val[31:0];
   endfunction

   function automatic hist_req_type random_req();
      hist_req_type r;
      int roll;
      logic [6:0] used_bins;
      roll = $urandom_range(99, 0);
      used_bins = (cfg_bins > 7'd64 || cfg_bins == 0) ? 7'd64 : cfg_bins;
      r.sample = $urandom;
      r.read_index = RIDX_W'($urandom);
      if (roll < 3) begin
         r.command = CMD_CLEAR;
      end else if (roll < 6) begin
         r.command = CMD_UNUSED;
      end else if (roll < 28) begin
         r.command = CMD_READ;
         // favor bins that can actually hold counts
         if ($urandom_range(1, 0) == 0)
            r.read_index = RIDX_W'($urandom_range(used_bins - 1, 0));
      end else begin
         r.command = CMD_ADD;
         if ($urandom_range(99, 0) < 85) r.sample = pick_sample();
      end
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset configuration: edges of -3.0 .. 3.0 in 20 bins.
      queue_req(CMD_READ,   32'hFFFF_FFFF, 6'd0);    // untouched bin reads zero
      queue_req(CMD_ADD,    32'hFFFD_0000, 6'd63);   // exactly the left edge
      queue_req(CMD_ADD,    32'hFFFC_FFFF, 6'd0);    // one LSB below, negative diff
      queue_req(CMD_ADD,    32'h7FFF_FFFF, 6'd0);    // largest sample
      queue_req(CMD_ADD,    32'h8000_0000, 6'd0);    // smallest sample
      queue_req(CMD_ADD,    32'h0002_B333, 6'd0);    // near the last bin
      queue_req(CMD_ADD,    32'h0003_0000, 6'd0);    // right edge
      queue_req(CMD_ADD,    32'h0000_0000, 6'd0);    // same bin twice in a row
      queue_req(CMD_ADD,    32'h0000_0000, 6'd0);
      queue_req(CMD_ADD,    32'hFFFF_FFFF, 6'd63);   // -1 LSB
      queue_req(CMD_READ,   32'h0000_0000, 6'd9);
      queue_req(CMD_READ,   32'h0000_0000, 6'd0);
      queue_req(CMD_READ,   32'h0000_0000, 6'd19);
      queue_req(CMD_READ,   32'h0000_0000, 6'd20);   // past bin_count, still stored
      queue_req(CMD_READ,   32'hFFFF_FFFF, 6'd63);
      queue_req(CMD_UNUSED, 32'hFFFF_FFFF, 6'd63);   // ignored, reports outside total
      queue_req(CMD_CLEAR,  32'hFFFF_FFFF, 6'd63);
      queue_req(CMD_READ,   32'h0000_0000, 6'd9);
      queue_req(CMD_UNUSED, 32'h0000_0000, 6'd0);
      queue_req(CMD_ADD,    32'h7FFF_FFFF, 6'd0);    // outside count restarts at one
      queue_req(CMD_ADD,    32'h0000_0000, 6'd0);
      queue_req(CMD_READ,   32'h0000_0000, 6'd9);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_drained();
         repeat (SETTLE_CYCLES) @(posedge clock);
         case (phase)
            0: begin                                  // width 1.0, all 64 bins
               csr_write(REG_LEFT_EDGE, 32'hFFFB_0000);
               csr_write(REG_INVERSE_WIDTH, 32'h0001_0000);
               csr_write(REG_BIN_COUNT, 32'd64);
            end
            1: begin                                  // zero slope: everything in bin 0
               csr_write(REG_LEFT_EDGE, $urandom);
               csr_write(REG_INVERSE_WIDTH, 32'd0);
               csr_write(REG_BIN_COUNT, 32'd1);
            end
            2: begin                                  // lowest bound, steepest slope
               csr_write(REG_LEFT_EDGE, 32'h8000_0000);
               csr_write(REG_INVERSE_WIDTH, 32'hFFFF_FFFF);
               csr_write(REG_BIN_COUNT, 32'd127);
            end
            3: begin                                  // no bins at all
               csr_write(REG_LEFT_EDGE, 32'h7FFF_FFFF);
               csr_write(REG_INVERSE_WIDTH, 32'd1);
               csr_write(REG_BIN_COUNT, 32'd0);
            end
            4: begin                                  // moderate random setting
               csr_write(REG_LEFT_EDGE,
                         $urandom_range(200 * 65536, 0) - 32'd100 * 65536);
               csr_write(REG_INVERSE_WIDTH, $urandom_range(32'h0010_0000, 32'h0000_1000));
               csr_write(REG_BIN_COUNT, $urandom_range(64, 1));
            end
            default: begin                            // anything goes, junk upper bits
               csr_write(REG_LEFT_EDGE, $urandom);
               csr_write(REG_INVERSE_WIDTH, $urandom);
               csr_write(REG_BIN_COUNT, $urandom);
            end
         endcase
         csr_valid <= 1'b0;

         // idle modes: none, sender gaps, receiver stalls, light on both
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
         endcase

         for (int n = 0; n < PHASE_ITEMS; n++) pending_req.push_back(random_req());
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (expected_rsp.size() != 0)
         report_mismatch("responses never returned", expected_rsp.size(), 0);

      $display("ran %0d adds in range, %0d out of range, %0d reads, %0d clears, %0d no-ops",
               adds_in, adds_out, reads_seen, clears_seen, nops_seen);
      $display("%0d register writes over %0d settings, %0d responses checked, %0d errors",
               csr_writes, PHASE_COUNT + 1, results_checked, error_count);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
